/* src/ifcm_pkg.sv */
package ifcm_pkg;

    localparam int COLOR_W   = 8;
    localparam int NUM_CH    = 3;
    localparam int NUM_STOPS = 6;
    localparam int NUM_SEGS  = NUM_STOPS - 1;
    localparam int SEG_W     = 3;
    localparam int POS_W     = 7;
    localparam int CODE_W    = 10;
    localparam int HUNDRED   = 100;

    // Channel indexes into a color triple.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Stop positions in hundredths of full scale.
    localparam logic [POS_W-1:0] STOP_POS [NUM_STOPS] = '{
        7'd0, 7'd20, 7'd35, 7'd50, 7'd75, 7'd100
    };

    // Stop colors: dark purple, blue, cyan, green, yellow, red.
    localparam logic [COLOR_W-1:0] STOP_RGB [NUM_STOPS][NUM_CH] = '{
        '{8'd48,  8'd0,   8'd96 },
        '{8'd0,   8'd0,   8'd255},
        '{8'd0,   8'd255, 8'd255},
        '{8'd0,   8'd255, 8'd0  },
        '{8'd255, 8'd255, 8'd0  },
        '{8'd255, 8'd0,   8'd0  }
    };

endpackage

/* src/ifcm_div_stage.sv */
module ifcm_div_stage
    import ifcm_pkg::*;
#(
    parameter int NW     = 30,
    parameter int DW     = 22,
    parameter int SW     = 9,
    parameter int BIT_HI = 7
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [NW-1:0]      i_n,
    input  logic [DW-1:0]      i_d,
    input  logic [COLOR_W-1:0] i_q,
    input  logic [SW-1:0]      i_side,
    output logic [NW-1:0]      o_n,
    output logic [DW-1:0]      o_d,
    output logic [COLOR_W-1:0] o_q,
    output logic [SW-1:0]      o_side
);

    logic [NW-1:0]      r_n, n_n;
    logic [DW-1:0]      r_d;
    logic [COLOR_W-1:0] r_q, n_q;
    logic [SW-1:0]      r_side;

    // Two restoring quotient bits per stage. The remainder always stays below
    // the divisor shifted to the next bit, so each bit is one compare.
    always_comb begin
        logic [NW-1:0] shifted;
        n_n = i_n;
        n_q = i_q;
        for (int b = BIT_HI; b >= BIT_HI - 1; b--) begin
            shifted = NW'(i_d) << b;
            if (n_n >= shifted) begin
                n_n = n_n - shifted;
                n_q = n_q | (COLOR_W'(1) << b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= n_n;
            r_d    <= i_d;
            r_q    <= n_q;
            r_side <= i_side;
        end
    end

    assign o_n    = r_n;
    assign o_d    = r_d;
    assign o_q    = r_q;
    assign o_side = r_side;

endmodule

/* src/intensity_false_color_map.sv */
// Piecewise-linear false-color map for a pixel stream.
//
// Each item on the input channel (i_valid, o_stall, i_intensity_code) is an
// intensity code k that stands for k/(INTENSITY_LEVELS-1); codes above the
// top level saturate to it. Each item on the output channel (o_valid,
// i_stall, o_red, o_green, o_blue) is the color between six fixed stops,
// dark purple, blue, cyan, green, yellow and red, with each channel rounded
// to nearest, halves away from zero.
//
// The pipeline has eight register stages. One item is accepted every clock
// cycle while o_stall is low; the rate is set by the stage that does one
// multiply per channel and by the four divider stages that each resolve two
// quotient bits per channel.
//
// Reset clears all valid bits, so the pipeline comes up empty. When the
// receiver stalls, the last stage holds its result, and earlier stages keep
// moving until they close up behind it; empty stages are filled, so a stall
// backs up to o_stall only once every stage holds an item.
module intensity_false_color_map
    import ifcm_pkg::*;
#(
    parameter int INTENSITY_LEVELS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [CODE_W-1:0]  i_intensity_code,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COLOR_W-1:0] o_red,
    output logic [COLOR_W-1:0] o_green,
    output logic [COLOR_W-1:0] o_blue
);

    // Top level T = INTENSITY_LEVELS-1 fits in TW bits.
    localparam int TW   = $clog2(INTENSITY_LEVELS);
    // Clamped code width, and the width used to compare a raw code with T.
    localparam int KCW  = (TW < CODE_W) ? TW : CODE_W;
    localparam int CW   = (TW > CODE_W) ? TW : CODE_W;
    // 100*k and stop*T are at most 100*T.
    localparam int PW   = TW + 7;
    // A segment span (at most 25 hundredths) times T.
    localparam int DENW = TW + 5;
    localparam int DW   = DENW + 1;
    // Dividend 2*num*|delta| + den stays below 512*den.
    localparam int NW   = DENW + 9;
    localparam int MW   = DENW + COLOR_W;
    localparam int SW   = COLOR_W + 1;
    localparam int NSTG = 8;
    localparam int DIV_STAGES = 4;
    localparam int DIV_FIRST  = 4;

    // Stop positions and segment spans scaled by T, fixed at elaboration.
    logic [PW-1:0]   w_pos [NUM_STOPS];
    logic [DENW-1:0] w_den [NUM_SEGS];

    for (genvar g = 0; g < NUM_STOPS; g++) begin : g_pos
        assign w_pos[g] = PW'(STOP_POS[g] * (INTENSITY_LEVELS - 1));
    end
    for (genvar g = 0; g < NUM_SEGS; g++) begin : g_den
        assign w_den[g] = DENW'((STOP_POS[g+1] - STOP_POS[g]) * (INTENSITY_LEVELS - 1));
    end

    // Handshake. A stage loads when it is empty or the stage after it moves.
    logic [NSTG:1] r_valid;
    logic [NSTG:1] w_en;

    always_comb begin
        w_en[NSTG] = !r_valid[NSTG] || !i_stall;
        for (int s = NSTG - 1; s >= 1; s--) begin
            w_en[s] = !r_valid[s] || w_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[1]) begin
                r_valid[1] <= i_valid;
            end
            for (int s = 2; s <= NSTG; s++) begin
                if (w_en[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    assign o_stall = !w_en[1];
    assign o_valid = r_valid[NSTG];

    // Stage 1: saturate the code to the top level.
    logic [KCW-1:0] r1_k;
    logic [CW-1:0]  w_raw;
    logic [CW-1:0]  w_top;
    logic [CW-1:0]  w_ksat;

    assign w_raw  = CW'(i_intensity_code);
    assign w_top  = CW'(INTENSITY_LEVELS - 1);
    assign w_ksat = (w_raw > w_top) ? w_top : w_raw;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_k <= w_ksat[KCW-1:0];
        end
    end

    // Stage 2: find the segment that ends at the first stop at or above k/T,
    // and the distance into it. Comparing 100*k with stop*T keeps it exact.
    logic [SEG_W-1:0] r2_seg, n2_seg;
    logic [DENW-1:0]  r2_num, n2_num;
    logic [PW-1:0]    w_hk;

    assign w_hk = PW'(r1_k) * PW'(HUNDRED);

    always_comb begin
        n2_seg = SEG_W'(NUM_SEGS - 1);
        for (int i = NUM_SEGS - 2; i >= 0; i--) begin
            if (w_hk <= w_pos[i+1]) begin
                n2_seg = SEG_W'(i);
            end
        end
        n2_num = DENW'(w_hk - w_pos[n2_seg]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_seg <= n2_seg;
            r2_num <= n2_num;
        end
    end

    // Stage 3: scale the distance by each channel's change and set up the
    // rounded division. A falling channel subtracts one from the dividend so
    // that its halves round toward the start color, which after the
    // subtraction in the last stage is rounding the value up.
    logic [NW-1:0]      r3_n [NUM_CH];
    logic [DW-1:0]      r3_d [NUM_CH];
    logic [SW-1:0]      r3_side [NUM_CH];
    logic [NW-1:0]      n3_n [NUM_CH];
    logic [SW-1:0]      n3_side [NUM_CH];
    logic [DENW-1:0]    w3_den;
    logic [SEG_W-1:0]   w3_next;

    assign w3_den  = w_den[r2_seg];
    assign w3_next = r2_seg + SEG_W'(1);

    always_comb begin
        logic [COLOR_W-1:0] c_start;
        logic [COLOR_W-1:0] c_end;
        logic [COLOR_W-1:0] c_mag;
        logic               c_neg;
        logic [MW-1:0]      c_prod;
        for (int c = 0; c < NUM_CH; c++) begin
            c_start = STOP_RGB[r2_seg][c];
            c_end   = STOP_RGB[w3_next][c];
            c_neg   = c_end < c_start;
            c_mag   = c_neg ? (c_start - c_end) : (c_end - c_start);
            c_prod  = MW'(r2_num) * MW'(c_mag);
            n3_n[c]    = NW'({c_prod, 1'b0}) + NW'(w3_den) - NW'(c_neg);
            n3_side[c] = {c_neg, c_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r3_n[c]    <= n3_n[c];
                r3_d[c]    <= {w3_den, 1'b0};
                r3_side[c] <= n3_side[c];
            end
        end
    end

    // Stages 4 to 7: eight-bit quotient, two bits per stage per channel.
    logic [NW-1:0]      w_n    [DIV_STAGES+1][NUM_CH];
    logic [DW-1:0]      w_d    [DIV_STAGES+1][NUM_CH];
    logic [COLOR_W-1:0] w_q    [DIV_STAGES+1][NUM_CH];
    logic [SW-1:0]      w_side [DIV_STAGES+1][NUM_CH];

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        assign w_n[0][c]    = r3_n[c];
        assign w_d[0][c]    = r3_d[c];
        assign w_q[0][c]    = '0;
        assign w_side[0][c] = r3_side[c];
        for (genvar st = 0; st < DIV_STAGES; st++) begin : g_st
            ifcm_div_stage #(
                .NW     (NW),
                .DW     (DW),
                .SW     (SW),
                .BIT_HI (COLOR_W - 1 - 2 * st)
            ) u_div (
                .i_clk  (i_clk),
                .i_en   (w_en[DIV_FIRST + st]),
                .i_n    (w_n[st][c]),
                .i_d    (w_d[st][c]),
                .i_q    (w_q[st][c]),
                .i_side (w_side[st][c]),
                .o_n    (w_n[st+1][c]),
                .o_d    (w_d[st+1][c]),
                .o_q    (w_q[st+1][c]),
                .o_side (w_side[st+1][c])
            );
        end
    end

    // Stage 8: apply the rounded offset to the start color.
    logic [COLOR_W-1:0] r8_rgb [NUM_CH];
    logic [COLOR_W-1:0] n8_rgb [NUM_CH];

    always_comb begin
        logic [SW-1:0]      c_side;
        logic [COLOR_W-1:0] c_q;
        for (int c = 0; c < NUM_CH; c++) begin
            c_side = w_side[DIV_STAGES][c];
            c_q    = w_q[DIV_STAGES][c];
            if (c_side[COLOR_W]) begin
                n8_rgb[c] = c_side[COLOR_W-1:0] - c_q;
            end else begin
                n8_rgb[c] = c_side[COLOR_W-1:0] + c_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r8_rgb[c] <= n8_rgb[c];
            end
        end
    end

    assign o_red   = r8_rgb[CH_RED];
    assign o_green = r8_rgb[CH_GREEN];
    assign o_blue  = r8_rgb[CH_BLUE];

endmodule

/* sim/intensity_false_color_map_test.sv */
// Streams intensity codes through the false-color map and compares every color
// that comes out against a color worked out here with exact integer arithmetic.
// A short directed list covers the ends of the code range, the codes on either
// side of each color stop and single-bit patterns. A random stream of about
// 1200 codes follows, with idle gaps on the input and stalls on the output.
module intensity_false_color_map_test
    import ifcm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int INTENSITY_LEVELS = 1024;
    localparam int NUM_RANDOM       = 1200;
    localparam int PHASE_LEN        = 100;
    localparam int PIPE_DEPTH       = 8;
    // No item moves on either side for this many cycles means the block hung.
    // The worst correct wait is a long output stall plus the pipeline depth.
    localparam int HANG_LIMIT       = 1000;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        t_rgb              color;
    } t_pending_color;

    // How much the input and output sides hold back during a phase.
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } t_idle_mode;

    // Holds the colors still owed by the block, oldest first, and works out
    // each one from its intensity code as it is accepted.
    class color_scoreboard;
        t_pending_color owed_q[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        // The code k stands for k/top. The segment is the first one whose end
        // stop lies at or above that value; on a stop the earlier segment ends
        // with fraction one. Positions are in hundredths, so comparisons and
        // the blend stay in integers: each channel is
        // (start*den + num*(end - start)) / den, rounded half up.
        function t_rgb map_code(logic [CODE_W-1:0] code);
            longint pos [NUM_STOPS] = '{0, 20, 35, 50, 75, 100};
            longint stop_color [NUM_STOPS][NUM_CH] = '{
                '{48, 0, 96}, '{0, 0, 255}, '{0, 255, 255},
                '{0, 255, 0}, '{255, 255, 0}, '{255, 0, 0}
            };
            longint top;
            longint k;
            longint num;
            longint den;
            longint total;
            longint v;
            int     seg;
            bit     found;
            logic [COLOR_W-1:0] chan [NUM_CH];
            t_rgb   c;

            top = INTENSITY_LEVELS - 1;
            k = code;
            if (k > top) begin
                k = top;
            end
            seg = NUM_STOPS - 2;
            found = 1'b0;
            for (int i = 0; i < NUM_STOPS - 1; i++) begin
                if (!found && 100 * k <= pos[i + 1] * top) begin
                    seg = i;
                    found = 1'b1;
                end
            end
            num = 100 * k - pos[seg] * top;
            den = (pos[seg + 1] - pos[seg]) * top;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                total = stop_color[seg][ch] * den
                      + num * (stop_color[seg + 1][ch] - stop_color[seg][ch]);
                if (total < 0) begin
                    total = 0;
                end
                v = (2 * total + den) / (2 * den);
                if (v > 255) begin
                    v = 255;
                end
                chan[ch] = v[COLOR_W-1:0];
            end
            c.red   = chan[CH_RED];
            c.green = chan[CH_GREEN];
            c.blue  = chan[CH_BLUE];
            return c;
        endfunction

        function void note_code(logic [CODE_W-1:0] code);
            t_pending_color p;
            p.code  = code;
            p.color = map_code(code);
            owed_q.push_back(p);
        endfunction

        function int owed();
            return owed_q.size();
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%0t ns: mismatch: %s", $time, what);
        endtask

        task check_color(t_rgb got);
            t_pending_color p;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("color (%0d,%0d,%0d) with no code waiting",
                                          got.red, got.green, got.blue));
            end else begin
                p = owed_q.pop_front();
                if (got.red !== p.color.red) begin
                    report_mismatch($sformatf("code %0d red %0d, expected %0d",
                                              p.code, got.red, p.color.red));
                end
                if (got.green !== p.color.green) begin
                    report_mismatch($sformatf("code %0d green %0d, expected %0d",
                                              p.code, got.green, p.color.green));
                end
                if (got.blue !== p.color.blue) begin
                    report_mismatch($sformatf("code %0d blue %0d, expected %0d",
                                              p.code, got.blue, p.color.blue));
                end
            end
        endtask
    endclass

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_valid          = 1'b0;
    logic [CODE_W-1:0]  i_intensity_code = '0;
    logic               o_stall;
    logic               o_valid;
    logic               i_stall          = 1'b0;
    logic [COLOR_W-1:0] o_red;
    logic [COLOR_W-1:0] o_green;
    logic [COLOR_W-1:0] o_blue;

    color_scoreboard sb;
    t_idle_mode      idle_mode = IDLE_NONE;
    int              hang_count = 0;

    intensity_false_color_map #(
        .INTENSITY_LEVELS(INTENSITY_LEVELS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_intensity_code(i_intensity_code),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Length of an idle gap or a stall. Most are short, a few are long, and in
    // a phase without idling there are none at all.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == IDLE_NONE) begin
            return 0;
        end
        if (idle_mode == IDLE_HEAVY) begin
            if (r < 30) return 0;
            if (r < 75) return $urandom_range(1, 4);
            return $urandom_range(5, 40);
        end
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Presents one item at a falling edge, after an optional idle gap, and
    // holds it until a rising edge finds o_stall low. Valid stays high from one
    // item to the next when there is no gap, so it is never dropped and raised
    // again within one time step. Returns at the falling edge after acceptance.
    task automatic send_code(input logic [CODE_W-1:0] code);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_intensity_code <= code;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Random code, mostly uniform, with extra weight on the codes around each
    // color stop, on both ends of the range and on single-bit patterns.
    function automatic logic [CODE_W-1:0] pick_code();
        int stop_codes [4] = '{205, 358, 511, 767};
        int r;
        int c;
        logic [CODE_W-1:0] bitpat;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return CODE_W'($urandom_range(0, 1023));
        end
        if (r < 80) begin
            c = stop_codes[$urandom_range(0, 3)] + $urandom_range(0, 4) - 2;
            return CODE_W'(c);
        end
        if (r < 90) begin
            if ($urandom_range(0, 1) == 0) begin
                return CODE_W'($urandom_range(0, 3));
            end
            return CODE_W'($urandom_range(1020, 1023));
        end
        bitpat = CODE_W'(1) << $urandom_range(0, CODE_W - 1);
        return ($urandom_range(0, 1) == 0) ? bitpat : ~bitpat;
    endfunction

    // Output side: runs of open cycles broken by stalls whose length follows
    // the current phase. Changes land on falling edges only.
    initial begin
        int stall_left;
        int open_left;
        stall_left = 0;
        open_left  = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idle_mode == IDLE_NONE) begin
                i_stall    <= 1'b0;
                stall_left = 0;
                open_left  = 0;
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                if (open_left > 0) begin
                    open_left--;
                end else begin
                    stall_left = gap_len();
                    open_left  = $urandom_range(0, 8);
                end
            end
        end
    end

    // Sampling at the rising edge sees the values from before the edge, since
    // the block's registers only change in the nonblocking update. Accepted
    // codes go to the scoreboard, accepted colors are checked against it, and
    // the watchdog counts edges at which neither side moved an item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_code(i_intensity_code);
            end
            if (o_valid && !i_stall) begin
                sb.check_color('{red: o_red, green: o_green, blue: o_blue});
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                hang_count <= 0;
            end else if (hang_count + 1 >= HANG_LIMIT) begin
                $display("%0t ns: no item moved for %0d cycles", $time, HANG_LIMIT);
                $display("** intensity_false_color_map: FAILED **");
                $finish;
            end else begin
                hang_count <= hang_count + 1;
            end
        end
    end

    initial begin
        logic [CODE_W-1:0] directed [$];
        sb = new();

        // Both ends of the range, the codes on either side of each stop (none
        // of the inner stops falls exactly on a code), and bit patterns.
        directed = '{10'd0, 10'd1, 10'd2, 10'd1023, 10'd1022,
                     10'd204, 10'd205, 10'd358, 10'd359, 10'd511, 10'd512,
                     10'd767, 10'd768, 10'h155, 10'h2AA, 10'h3FF, 10'h200,
                     10'h1FF, 10'h001, 10'h3FE, 10'd102, 10'd300, 10'd640};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_mode = IDLE_LIGHT;
        foreach (directed[i]) begin
            send_code(directed[i]);
        end

        // The random stream runs in phases, each with its own amount of
        // idling, so gaps and stalls hit the pipeline both empty and full.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % PHASE_LEN == 0) begin
                idle_mode = t_idle_mode'($urandom_range(0, 2));
            end
            send_code(pick_code());
        end
        i_valid <= 1'b0;

        while (sb.owed() != 0) begin
            @(posedge i_clk);
        end
        // Leave time for any stray color to show up after the last one.
        repeat (3 * PIPE_DEPTH) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("** intensity_false_color_map: PASSED **");
        end else begin
            $display("** intensity_false_color_map: FAILED **");
        end
        $finish;
    end

endmodule
